@@ design/fam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered accelerometer magnitude package
// Widths, payload types and codes shared by the interfaces and the modules.
// ----------------------------------------------------------------------------
package fam_pkg;

	// Raw axis sample width and derived datapath widths.
	localparam int AXIS_W     = 16;
	localparam int SQ_W       = 2 * AXIS_W;
	localparam int ROOT_W     = AXIS_W + 1;
	localparam int SUM_W      = 2 * ROOT_W;
	localparam int MAG_W      = 16;

	// Filter output is unsigned fixed point with OUT_FRAC fraction bits.
	localparam int OUT_FRAC   = 16;
	localparam int FILT_W     = MAG_W + OUT_FRAC;
	localparam int DIFF_W     = FILT_W + 1;
	localparam int PHI_W      = DIFF_W + 1;

	// Smoothing coefficient, unsigned with ALPHA_FRAC fraction bits.
	localparam int ALPHA_FRAC = 16;
	localparam int ALPHA_W    = ALPHA_FRAC + 1;
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;
	localparam logic [ALPHA_W-1:0] ALPHA_MIN = ALPHA_ONE / 100;

	localparam int SEED_W     = 16;
	localparam int CFG_DATA_W = ALPHA_W;
	localparam int STEP_W     = $clog2(ALPHA_W + AXIS_W + 1);

	typedef enum logic {
		OP_SAMPLE  = 1'b0,
		OP_RESTART = 1'b1
	} fam_op_t;

	typedef enum logic {
		REG_ALPHA = 1'b0,
		REG_SEED  = 1'b1
	} fam_reg_t;

	typedef struct packed {
		fam_op_t                   opcode;
		logic signed [AXIS_W-1:0]  accel_x;
		logic signed [AXIS_W-1:0]  accel_y;
		logic signed [AXIS_W-1:0]  accel_z;
	} fam_in_t;

	typedef struct packed {
		logic [MAG_W-1:0] raw_magnitude;
		logic [MAG_W-1:0] smoothed_magnitude;
	} fam_out_t;

	typedef struct packed {
		fam_reg_t              index;
		logic [CFG_DATA_W-1:0] wdata;
	} fam_cfg_t;

endpackage

@@ design/fam_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered accelerometer magnitude channels
// Valid/ready channels for sample items, result items and register writes.
// ----------------------------------------------------------------------------
interface fam_in_if;
	logic             valid;
	logic             ready;
	fam_pkg::fam_in_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fam_out_if;
	logic              valid;
	logic              ready;
	fam_pkg::fam_out_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface fam_cfg_if;
	logic              valid;
	logic              ready;
	fam_pkg::fam_cfg_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ design/fam_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bit-serial integer square root
// Restoring recurrence that retires one root bit per cycle.
// ----------------------------------------------------------------------------
module fam_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fam_pkg::SUM_W-1:0]  radicand,
	output logic                       done,
	output logic [fam_pkg::ROOT_W-1:0] root
);
	import fam_pkg::*;

	localparam int REM_W = ROOT_W + 2;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [ROOT_W-1:0] root_q;

	logic [REM_W:0]   rem_sh;
	logic [REM_W:0]   trial;
	logic [REM_W:0]   rem_sub;
	logic             take;

	// Bring down the next two radicand bits and try the root bit as one.
	always_comb begin
		rem_sh  = {rem_q[REM_W-2:0], rad_q[SUM_W-1 -: 2]};
		trial   = {1'b0, root_q, 2'b01};
		rem_sub = rem_sh - trial;
		take    = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
			rem_q  <= take ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
			root_q <= {root_q[ROOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

@@ design/filtered_accel_magnitude_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered accelerometer magnitude
// Vector magnitude of a three-axis sample and its exponential moving average.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      contents
//   samples   in    valid/ready    opcode, accel_x, accel_y, accel_z
//   results   out   valid/ready    raw_magnitude, smoothed_magnitude
//   cfg       in    valid/ready    index (0 alpha, 1 seed), wdata
//
// A seeded sample item holds the block while it passes through the
// shift-add squarers, the sum, the square root unit (one root bit per
// cycle), the serial alpha multiply, and control (accept, filter update,
// result load). An unseeded sample skips the multiply and the update. A
// restart item produces no result. Reset is asynchronous and leaves alpha
// at 1.0, seed at 0 and the filter unseeded. A stalled result waits in the
// output register; the block holds off new items until the pending result
// is loaded there.
//
// The squares are formed by three shift-add units that look at one bit of
// the multiplier per cycle, the root by a restoring recurrence, and the
// filter product alpha * (x - prev) by a shift-add unit that consumes one
// bit of alpha per cycle. Since alpha never exceeds 1.0, the new filter
// value lies between the old one and the new magnitude, so it needs no
// clamping.
// ----------------------------------------------------------------------------
module filtered_accel_magnitude_top (
	input  logic      clk,
	input  logic      arst_n,
	fam_in_if.sink    samples,
	fam_out_if.source results,
	fam_cfg_if.sink   cfg
);
	import fam_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SQUARE,
		S_SUM,
		S_ROOT,
		S_EMA,
		S_UPDATE,
		S_FINISH
	} state_t;

	state_t state_q;
	logic [STEP_W-1:0] cnt_q;

	// Architectural state and registers.
	logic [ALPHA_W-1:0] alpha_q;
	logic [SEED_W-1:0]  seed_q;
	logic [FILT_W-1:0]  filter_q;
	logic               seeded_q;

	// Result register.
	logic     res_valid_q;
	fam_out_t res_data_q;

	// Serial datapath registers.
	logic [AXIS_W-1:0]       mcand_q [3];
	logic [SQ_W-1:0]         prod_q  [3];
	logic [MAG_W-1:0]        mag_q;
	logic signed [DIFF_W-1:0] diff_q;
	logic signed [PHI_W-1:0]  p_hi_q;
	logic [ALPHA_W-1:0]      p_lo_q;

	// Combinational helpers.
	logic [AXIS_W-1:0]  axis_abs [3];
	logic [AXIS_W:0]    sq_add   [3];
	logic [SUM_W-1:0]   sum_sq;
	logic               sqrt_done;
	logic [ROOT_W-1:0]  sqrt_root;
	logic [MAG_W-1:0]   mag_sat;
	logic [PHI_W:0]     ema_add;
	logic [PHI_W:0]     filt_next;
	logic [FILT_W:0]    rnd_sum;
	logic [MAG_W:0]     rnd_top;
	logic [MAG_W-1:0]   smooth;
	logic [ALPHA_W-1:0] alpha_wr;
	logic               in_accept;
	logic               res_free;

	assign in_accept = samples.valid && samples.ready;
	assign res_free  = !res_valid_q || results.ready;

	// Magnitudes of the incoming axes, taken as unsigned so that the most
	// negative count still squares correctly.
	always_comb begin
		axis_abs[0] = samples.data.accel_x[AXIS_W-1] ?
			(~samples.data.accel_x + AXIS_W'(1)) : samples.data.accel_x;
		axis_abs[1] = samples.data.accel_y[AXIS_W-1] ?
			(~samples.data.accel_y + AXIS_W'(1)) : samples.data.accel_y;
		axis_abs[2] = samples.data.accel_z[AXIS_W-1] ?
			(~samples.data.accel_z + AXIS_W'(1)) : samples.data.accel_z;
	end

	// One shift-add step per axis: add the multiplicand into the upper
	// half when the current multiplier bit is set.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sq_add[i] = {1'b0, prod_q[i][SQ_W-1:AXIS_W]} +
				(prod_q[i][0] ? {1'b0, mcand_q[i]} : '0);
		end
		sum_sq = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);
	end

	fam_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_SUM),
		.radicand (sum_sq),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	// The root of three squared 16-bit counts stays within 16 bits, but the
	// top bit is kept so a wider axis saturates instead of wrapping.
	assign mag_sat = (|sqrt_root[ROOT_W-1:MAG_W]) ? '1 : sqrt_root[MAG_W-1:0];

	// Signed shift-add step of alpha * diff, one alpha bit per cycle. The
	// upper half is shifted arithmetically so the product keeps its sign.
	always_comb begin
		ema_add = {p_hi_q[PHI_W-1], p_hi_q} +
			(p_lo_q[0] ? {{2{diff_q[DIFF_W-1]}}, diff_q} : '0);
		// Dropping the low ALPHA_FRAC product bits is a floor division.
		filt_next = {p_hi_q, p_lo_q[ALPHA_W-1:ALPHA_FRAC]} +
			{{(PHI_W + 1 - FILT_W){1'b0}}, filter_q};
	end

	// Round half up to an integer and saturate.
	always_comb begin
		rnd_sum = {1'b0, filter_q} + ((FILT_W + 1)'(1) << (OUT_FRAC - 1));
		rnd_top = rnd_sum[FILT_W:OUT_FRAC];
		smooth  = rnd_top[MAG_W] ? '1 : rnd_top[MAG_W-1:0];
	end

	// Alpha is clamped to the range 0.01 .. 1.0 as it is written.
	always_comb begin
		alpha_wr = cfg.data.wdata[ALPHA_W-1:0];
		if (alpha_wr < ALPHA_MIN) begin
			alpha_wr = ALPHA_MIN;
		end else if (alpha_wr > ALPHA_ONE) begin
			alpha_wr = ALPHA_ONE;
		end
	end

	// Sequencer, architectural state and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			alpha_q     <= ALPHA_ONE;
			seed_q      <= '0;
			filter_q    <= '0;
			seeded_q    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			// A new result may be loaded in the same cycle the old one leaves.
			if (state_q == S_FINISH && res_free) begin
				res_valid_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				res_valid_q <= 1'b0;
			end

			if (cfg.valid) begin
				unique case (cfg.data.index)
					REG_ALPHA: alpha_q <= alpha_wr;
					REG_SEED:  seed_q  <= cfg.data.wdata[SEED_W-1:0];
					default:   ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						if (samples.data.opcode == OP_RESTART) begin
							filter_q <= {seed_q, {OUT_FRAC{1'b0}}};
							seeded_q <= (seed_q != '0);
						end else begin
							cnt_q   <= '0;
							state_q <= S_SQUARE;
						end
					end
				end
				S_SQUARE: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(AXIS_W - 1)) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (sqrt_done) begin
						if (!seeded_q) begin
							filter_q <= {mag_sat, {OUT_FRAC{1'b0}}};
							seeded_q <= 1'b1;
							state_q  <= S_FINISH;
						end else begin
							cnt_q   <= '0;
							state_q <= S_EMA;
						end
					end
				end
				S_EMA: begin
					cnt_q <= cnt_q + STEP_W'(1);
					if (cnt_q == STEP_W'(ALPHA_W - 1)) begin
						state_q <= S_UPDATE;
					end
				end
				S_UPDATE: begin
					filter_q <= filt_next[FILT_W-1:0];
					state_q  <= S_FINISH;
				end
				S_FINISH: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers, loaded under control of the sequencer.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_accept) begin
			for (int i = 0; i < 3; i++) begin
				mcand_q[i] <= axis_abs[i];
				prod_q[i]  <= {{AXIS_W{1'b0}}, axis_abs[i]};
			end
		end else if (state_q == S_SQUARE) begin
			for (int i = 0; i < 3; i++) begin
				prod_q[i] <= {sq_add[i], prod_q[i][AXIS_W-1:1]};
			end
		end

		if (state_q == S_ROOT && sqrt_done) begin
			mag_q  <= mag_sat;
			diff_q <= {1'b0, mag_sat, {OUT_FRAC{1'b0}}} - {1'b0, filter_q};
			p_hi_q <= '0;
			p_lo_q <= alpha_q;
		end else if (state_q == S_EMA) begin
			p_hi_q <= ema_add[PHI_W:1];
			p_lo_q <= {ema_add[0], p_lo_q[ALPHA_W-1:1]};
		end

		if (state_q == S_FINISH && res_free) begin
			res_data_q.raw_magnitude      <= mag_q;
			res_data_q.smoothed_magnitude <= smooth;
		end
	end

	assign samples.ready = (state_q == S_IDLE);
	assign results.valid = res_valid_q;
	assign results.data  = res_data_q;
	assign cfg.ready     = 1'b1;

endmodule

@@ tb/tb_filtered_accel_magnitude_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filtered accelerometer magnitude testbench
// Drives sample and restart items into the block under random idling and
// backpressure. It predicts each result from its own model of the magnitude
// and the moving-average filter, and checks every returned result item.
// ----------------------------------------------------------------------------
module tb_filtered_accel_magnitude_top;
	import fam_pkg::*;

	typedef logic signed [AXIS_W-1:0] axis_t;

	// The pause before a register write outlasts the slowest item, so
	// nothing can still be in flight.
	localparam int DRAIN_CYCLES = 80;
	// Long receiver hold-off that lets the block fill up and stall its input.
	localparam int HOLD_CYCLES  = 400;
	// Watchdog limit for the whole run.
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RAND_PHASES  = 8;
	localparam int PHASE_ITEMS  = 205;
	localparam int MAX_REPORTS  = 10;

	logic clk;
	logic arst_n;

	fam_in_if  samples_if ();
	fam_out_if results_if ();
	fam_cfg_if cfg_if ();

	filtered_accel_magnitude_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.results (results_if),
		.cfg     (cfg_if)
	);

	// Free-running 2 ns clock.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Predicted state of the block. The filter output is unsigned Q16.16 and
	// the coefficient is Q1.16 where 65536 stands for 1.0.
	// ------------------------------------------------------------------------
	logic [ALPHA_W-1:0]     alpha_q16  = ALPHA_ONE;
	logic [SEED_W-1:0]      seed_int   = '0;
	logic [FILT_W-1:0]      filt_q16   = '0;
	logic                   filt_loaded = 1'b0;

	// Results the block still owes, oldest first.
	fam_out_t pending_results[$];

	int err_count    = 0;
	int results_seen = 0;
	int tx_max_gap   = 0;
	int rx_max_gap   = 0;
	int rx_gap       = 0;
	logic rx_hold    = 1'b0;
	event hold_start;

	// Floor square root by trial bits, most significant first. The widest
	// sum of three squared 16-bit axes needs a 16-bit root at most.
	function automatic longint unsigned floor_root(input longint unsigned n);
		longint unsigned root;
		longint unsigned trial;
		root = 0;
		for (int b = ROOT_W - 1; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= n)
				root = trial;
		end
		return root;
	endfunction

	// Register write as the block sees it: alpha is clamped into its legal
	// range, the seed keeps its low 16 bits and leaves the filter alone.
	function automatic void apply_reg_write(input fam_reg_t idx,
	                                        input logic [CFG_DATA_W-1:0] wdata);
		case (idx)
			REG_ALPHA: begin
				if (wdata < ALPHA_MIN)
					alpha_q16 = ALPHA_MIN;
				else if (wdata > ALPHA_ONE)
					alpha_q16 = ALPHA_ONE;
				else
					alpha_q16 = wdata;
			end
			REG_SEED: begin
				seed_int = wdata[SEED_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Advances the predicted state by one accepted item and queues the
	// result that a sample item must produce. A restart yields nothing.
	function automatic void predict_item(input fam_in_t item);
		longint          sx, sy, sz;
		longint unsigned sum_sq, mag, rounded;
		longint          mag_q16, diff, step, next_filt;
		fam_out_t        res;

		if (item.opcode == OP_RESTART) begin
			filt_q16    = FILT_W'(seed_int) << OUT_FRAC;
			filt_loaded = (seed_int != 0);
			return;
		end

		sx = $signed(item.accel_x);
		sy = $signed(item.accel_y);
		sz = $signed(item.accel_z);
		sum_sq = longint'(sx * sx) + longint'(sy * sy) + longint'(sz * sz);
		mag = floor_root(sum_sq);
		if (mag > 65535)
			mag = 65535;

		if (!filt_loaded) begin
			// The first sample after an unseeded start loads the filter.
			filt_q16    = FILT_W'(mag << OUT_FRAC);
			filt_loaded = 1'b1;
		end else begin
			mag_q16   = longint'(mag) <<< OUT_FRAC;
			diff      = mag_q16 - longint'(filt_q16);
			step      = (longint'(alpha_q16) * diff) >>> ALPHA_FRAC;
			next_filt = longint'(filt_q16) + step;
			if (next_filt < 0)
				next_filt = 0;
			if (next_filt > 64'sh0000_0000_FFFF_FFFF)
				next_filt = 64'sh0000_0000_FFFF_FFFF;
			filt_q16 = FILT_W'(next_filt);
		end

		// Round half up, saturating at the top of the 16-bit result.
		rounded = (longint'(filt_q16) + (64'd1 << (OUT_FRAC - 1))) >> OUT_FRAC;
		if (rounded > 65535)
			rounded = 65535;

		res.raw_magnitude      = MAG_W'(mag);
		res.smoothed_magnitude = MAG_W'(rounded);
		pending_results.push_back(res);
	endfunction

	function automatic void note_error(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, msg);
	endfunction

	function automatic void check_result(input fam_out_t got);
		fam_out_t want;
		results_seen++;
		if (pending_results.size() == 0) begin
			note_error($sformatf("result %0d arrived with none expected (raw %0d, smoothed %0d)",
				results_seen, got.raw_magnitude, got.smoothed_magnitude));
			return;
		end
		want = pending_results.pop_front();
		if (got.raw_magnitude !== want.raw_magnitude)
			note_error($sformatf("result %0d raw_magnitude expected %0d got %0d",
				results_seen, want.raw_magnitude, got.raw_magnitude));
		if (got.smoothed_magnitude !== want.smoothed_magnitude)
			note_error($sformatf("result %0d smoothed_magnitude expected %0d got %0d",
				results_seen, want.smoothed_magnitude, got.smoothed_magnitude));
	endfunction

	// ------------------------------------------------------------------------
	// Result side. Every accepted item is checked, then the receiver draws
	// how many cycles it keeps ready low before the next one. The long hold
	// from the process below overrides that draw.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			check_result(results_if.data);
			rx_gap = $urandom_range(0, rx_max_gap);
		end else if (rx_gap != 0) begin
			rx_gap--;
		end
		results_if.ready <= (rx_gap == 0) && !rx_hold;
	end

	// Long hold-off of the receiver, counted here so that the sender keeps
	// offering items meanwhile.
	initial begin
		forever begin
			@(hold_start);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[filtered_accel_magnitude_top] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// Offers one item after a random gap and waits until the block takes it.
	// Valid is left high on return; the next send or the idle wait decides
	// in the same step whether it drops.
	task automatic send_item(input fam_in_t item);
		int gap;
		gap = $urandom_range(0, tx_max_gap);
		if (gap != 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.data  <= item;
		do @(posedge clk); while (samples_if.ready !== 1'b1);
		predict_item(item);
	endtask

	// Stops offering items, waits until every predicted result has come
	// back, then lets a restart still in flight finish.
	task automatic wait_idle();
		samples_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes both registers back to back. Only called while the block idles.
	task automatic configure(input logic [CFG_DATA_W-1:0] alpha_w,
	                         input logic [CFG_DATA_W-1:0] seed_w);
		fam_cfg_t wr;
		wr.index = REG_ALPHA;
		wr.wdata = alpha_w;
		cfg_if.valid <= 1'b1;
		cfg_if.data  <= wr;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		apply_reg_write(wr.index, wr.wdata);
		wr.index = REG_SEED;
		wr.wdata = seed_w;
		cfg_if.data <= wr;
		do @(posedge clk); while (cfg_if.ready !== 1'b1);
		apply_reg_write(wr.index, wr.wdata);
		cfg_if.valid <= 1'b0;
	endtask

	function automatic fam_in_t make_sample(input axis_t x, input axis_t y, input axis_t z);
		fam_in_t item;
		item.opcode  = OP_SAMPLE;
		item.accel_x = x;
		item.accel_y = y;
		item.accel_z = z;
		return item;
	endfunction

	// A restart carries random axis fields, which the block must ignore.
	function automatic fam_in_t make_restart();
		fam_in_t item;
		item.opcode  = OP_RESTART;
		item.accel_x = axis_t'($urandom);
		item.accel_y = axis_t'($urandom);
		item.accel_z = axis_t'($urandom);
		return item;
	endfunction

	// Axis values lean toward the extremes and toward small readings, where
	// the root and the filter are most likely to go wrong.
	function automatic axis_t rand_axis();
		int pick;
		pick = $urandom_range(0, 7);
		case (pick)
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return axis_t'(int'($urandom_range(0, 64)) - 32);
			3: return axis_t'(int'($urandom_range(0, 4000)) - 2000);
			default: return axis_t'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Out of reset alpha is 1.0 and the filter unseeded: the first sample
	// loads the filter, and later ones track the magnitude exactly.
	task automatic test_reset_defaults();
		tx_max_gap = 6;
		rx_max_gap <= 6;
		send_item(make_sample(16'sh0000, 16'sh0000, 16'sh0000));
		send_item(make_sample(16'sh8000, 16'sh8000, 16'sh8000));
		send_item(make_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF));
		send_item(make_sample(16'sh8000, 16'sh0000, 16'sh0000));
		send_item(make_sample(16'sh0000, 16'sh7FFF, 16'shFFFF));
		send_item(make_sample(16'sh5555, 16'shAAAA, 16'sh0001));
		send_item(make_sample(16'shAAAA, 16'sh5555, 16'shFFFE));
		wait_idle();
	endtask

	// Alpha writes outside the legal range are clamped to 0.01 and 1.0.
	task automatic test_alpha_clamp();
		configure(17'h00000, 17'h00000);
		send_item(make_sample(16'sh8000, 16'sh8000, 16'sh8000));
		send_item(make_sample(16'sh0000, 16'sh0000, 16'sh0001));
		wait_idle();
		configure(17'h1FFFF, 17'h00000);
		send_item(make_sample(16'sh0003, 16'sh0004, 16'sh0000));
		wait_idle();
		configure(17'd654, 17'h00000);
		send_item(make_sample(16'sh7FFF, 16'sh0000, 16'sh0000));
		wait_idle();
		configure(17'd65537, 17'h00000);
		send_item(make_sample(16'sh1234, 16'shEDCB, 16'sh0F0F));
		wait_idle();
	endtask

	// Restart with a zero seed leaves the filter unseeded; a nonzero seed
	// preloads it. Writing the seed alone must not disturb the filter.
	task automatic test_seed_restart();
		configure(17'd32768, 17'd0);
		send_item(make_restart());
		send_item(make_sample(16'sh0003, 16'sh0004, 16'sh0000));
		send_item(make_sample(16'sh0000, 16'sh0000, 16'sh0000));
		wait_idle();
		configure(17'd32768, 17'd1000);
		send_item(make_sample(16'sh0100, 16'sh0000, 16'sh0000));
		send_item(make_restart());
		send_item(make_sample(16'sh0100, 16'sh0000, 16'sh0000));
		wait_idle();
		// Bit 16 of the seed write falls away, leaving the largest seed.
		configure(17'd655, 17'h1FFFF);
		send_item(make_restart());
		send_item(make_sample(16'sh0000, 16'sh0000, 16'sh0000));
		wait_idle();
		configure(17'd40000, 17'd1);
		send_item(make_restart());
		send_item(make_sample(16'sh8000, 16'sh7FFF, 16'sh8000));
		wait_idle();
	endtask

	// The receiver stops for a long stretch while items keep coming, so the
	// block has to hold its result and push back on its input.
	task automatic test_output_backpressure();
		configure(17'd20000, 17'd0);
		tx_max_gap = 0;
		rx_max_gap <= 0;
		-> hold_start;
		for (int i = 0; i < 40; i++)
			send_item(make_sample(rand_axis(), rand_axis(), rand_axis()));
		wait_idle();
	endtask

	// Random items over several register settings, the extremes among them.
	// Some phases run with no idling on either side.
	task automatic test_random_traffic();
		logic [CFG_DATA_W-1:0] alpha_w;
		logic [CFG_DATA_W-1:0] seed_w;
		fam_in_t               item;
		for (int p = 0; p < RAND_PHASES; p++) begin
			case (p)
				0: alpha_w = 17'h00000;
				1: alpha_w = 17'h1FFFF;
				2: alpha_w = ALPHA_MIN;
				3: alpha_w = ALPHA_ONE;
				4: alpha_w = CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
				default: alpha_w = CFG_DATA_W'($urandom_range(ALPHA_MIN, ALPHA_ONE));
			endcase
			seed_w = (p % 2 == 1) ? CFG_DATA_W'($urandom) : '0;
			configure(alpha_w, seed_w);
			tx_max_gap = (p % 4 == 0) ? 0 : 6;
			rx_max_gap <= (p % 4 == 0 || p == 5) ? 0 : 6;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 19) == 0)
					item = make_restart();
				else
					item = make_sample(rand_axis(), rand_axis(), rand_axis());
				send_item(item);
			end
			wait_idle();
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence: reset once, run the tests in turn, report. The result
	// side drives its own ready from the first clock edge on.
	// ------------------------------------------------------------------------
	initial begin
		arst_n           = 1'b0;
		samples_if.valid = 1'b0;
		samples_if.data  = '0;
		cfg_if.valid     = 1'b0;
		cfg_if.data      = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_alpha_clamp();
		test_seed_restart();
		test_output_backpressure();
		test_random_traffic();

		if (err_count == 0)
			$display("[filtered_accel_magnitude_top] OK");
		else
			$display("[filtered_accel_magnitude_top] ERROR");
		$finish;
	end

endmodule

@@ sim.f @@
design/fam_pkg.sv
design/fam_if.sv
design/fam_sqrt.sv
design/filtered_accel_magnitude_top.sv
tb/tb_filtered_accel_magnitude_top.sv
